FILE: design/assert_macros.svh
// assertion helpers for the sorted priority queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define SPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("spq assertion failed");
// trigger implies consequence in the following cycle
`define SPQ_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("spq assertion failed");
`else
`define SPQ_ASSERT(label, clk, rst_n, prop)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif
`endif

FILE: design/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    // positions reachable by a read request
    localparam int READ_SPAN = 1 << INDEX_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_READ    = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_INDEX = 2'd3
    } status_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                      insert;
        logic                      extract;
        logic                      read;
        logic signed [VALUE_W-1:0] new_value;
    } cell_ctrl_t;

endpackage

FILE: design/spq_req_if.sv
`timescale 1ns / 1ps
interface spq_req_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] new_value;
    logic [INDEX_W-1:0]        read_index;

    modport source (output valid, output req_type, output new_value, output read_index,
                    input ready);
    modport sink   (input valid, input req_type, input new_value, input read_index,
                    output ready);
endinterface

FILE: design/spq_rsp_if.sv
`timescale 1ns / 1ps
interface spq_rsp_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_value;
    logic [COUNT_W-1:0]        entry_count;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output out_value, output entry_count, output status,
                    input ready);
    modport sink   (input valid, input out_value, input entry_count, input status,
                    output ready);
endinterface

FILE: design/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// a request's response is valid in the cycle after the request transfers
// throughput: one request per cycle while the response side keeps taking results,
//   set by the cell row and the output register both updating on each transfer
// reset: count and every occupancy bit clear at once; stored values are left as is
//   and need no clearing pass since unoccupied cells are never read
`include "assert_macros.svh"
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);

    // count register wide enough to hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W + 1 : INDEX_W + 1;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                      rsp_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [COUNT_W-1:0]        entry_count_reg;
    logic [STATUS_W-1:0]       status_reg;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic                      index_ok;
    logic [STATUS_W-1:0]       status_next;
    logic [VALUE_W-1:0]        result_value;
    cell_ctrl_t                ctrl;

    logic                      lt_w    [DEPTH];
    logic                      occ_w   [DEPTH];
    logic signed [VALUE_W-1:0] value_w [DEPTH];
    logic [VALUE_W-1:0]        bus_w   [DEPTH];
    logic                      hit_w   [DEPTH];

    // a new request is taken whenever the output register is free or draining
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign index_ok = CMP_W'(req.read_index) < CMP_W'(count_reg);

    // decode the request and broadcast it along the row
    always_comb
    begin
        ctrl.insert    = 1'b0;
        ctrl.extract   = 1'b0;
        ctrl.read      = 1'b0;
        ctrl.new_value = req.new_value;
        count_next     = count_reg;
        status_next    = ST_OK;
        unique case (req_t'(req.req_type))
            REQ_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.insert = accept;
                    count_next  = count_reg + 1'b1;
                end
            end
            REQ_EXTRACT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctrl.extract = accept;
                    count_next   = count_reg - 1'b1;
                end
            end
            REQ_READ:
            begin
                ctrl.read = accept;
                if (!index_ok)
                begin
                    status_next = ST_INDEX;
                end
            end
            default:
            begin
                // unused code: no change, zero value, status ok
            end
        endcase
    end

    // row of cells, ascending from cell 0; occupancy is a thermometer code
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                      prev_lt;
        logic                      prev_occ;
        logic signed [VALUE_W-1:0] prev_value;
        logic                      next_occ;

        if (i == 0)
        begin : g_head
            assign prev_lt    = 1'b1;
            assign prev_occ   = 1'b1;
            assign prev_value = req.new_value;
        end
        else
        begin : g_body
            assign prev_lt    = lt_w[i-1];
            assign prev_occ   = occ_w[i-1];
            assign prev_value = value_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_occ = 1'b0;
        end
        else
        begin : g_inner
            assign next_occ = occ_w[i+1];
        end

        // only the first positions are reachable by a read index
        if (i < READ_SPAN)
        begin : g_readable
            assign hit_w[i] = (req.read_index == INDEX_W'(i));
        end
        else
        begin : g_unreadable
            assign hit_w[i] = 1'b0;
        end

        spq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .read_hit   (hit_w[i]),
            .prev_lt    (prev_lt),
            .prev_occ   (prev_occ),
            .prev_value (prev_value),
            .next_occ   (next_occ),
            .lt         (lt_w[i]),
            .occ        (occ_w[i]),
            .value      (value_w[i]),
            .bus_value  (bus_w[i])
        );
    end

    // at most one cell drives the bus, the rest give zero
    always_comb
    begin
        result_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            result_value = result_value | bus_w[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // response payload, loaded on each request transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg   <= $signed(result_value);
            entry_count_reg <= COUNT_W'(count_next);
            status_reg      <= status_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.out_value   = out_value_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.status      = status_reg;

    // occupancy bits and the count must agree
    logic [DEPTH-1:0] occ_vec;
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            occ_vec[i] = occ_w[i];
        end
    end

    `SPQ_ASSERT(a_count_matches_occ, clk, rst_n, $countones(occ_vec) == int'(count_reg))
    `SPQ_ASSERT(a_full_is_top_cell, clk, rst_n, full == occ_w[DEPTH-1])
    `SPQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctrl.insert, count_reg == $past(count_reg) + 1'b1)
    `SPQ_ASSERT_NEXT(a_extract_shrinks, clk, rst_n, ctrl.extract, count_reg == $past(count_reg) - 1'b1)

endmodule

FILE: design/spq_cell.sv
`timescale 1ns / 1ps
module spq_cell
    import spq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_ctrl_t                ctrl,
    input  logic                      read_hit,
    input  logic                      prev_lt,
    input  logic                      prev_occ,
    input  logic signed [VALUE_W-1:0] prev_value,
    input  logic                      next_occ,
    output logic                      lt,
    output logic                      occ,
    output logic signed [VALUE_W-1:0] value,
    output logic [VALUE_W-1:0]        bus_value
);

    logic                      occ_reg;
    logic                      occ_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      last;
    logic                      hit;

    assign lt    = occ_reg && (value_reg < ctrl.new_value);
    assign last  = occ_reg && !next_occ;
    assign occ   = occ_reg;
    assign value = value_reg;

    // drive the shared result bus when extracted or read
    assign hit       = (ctrl.extract && last) || (ctrl.read && read_hit && occ_reg);
    assign bus_value = hit ? VALUE_W'(value_reg) : '0;

    always_comb
    begin
        occ_next   = occ_reg;
        value_next = value_reg;
        if (ctrl.insert)
        begin
            occ_next = occ_reg || prev_occ;
            if (!lt)
            begin
                // first cell not below the new value takes it, the rest shift up
                value_next = prev_lt ? ctrl.new_value : prev_value;
            end
        end
        else if (ctrl.extract && last)
        begin
            occ_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    // request code with no meaning to the block, must be ignored
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    // cycles with no transfer on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // window of cycles in which neither side idles
    localparam int QUIET_START = 1000;
    localparam int QUIET_END   = 1600;
    localparam int RANDOM_ITEMS = 2000;
    localparam int IDLE_PCT = 26;

    // one request as it goes onto the request channel
    typedef struct packed {
        logic [REQ_W-1:0]          kind;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } queue_req_t;

    // one response as the queue should return it
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
        status_t                   status;
    } queue_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue_top #(
        .DEPTH (QUEUE_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // requests waiting to be driven, and responses still owed by the queue
    queue_req_t pending_reqs[$];
    queue_rsp_t expected_rsps[$];

    // shadow copy of the queue contents, kept in ascending order
    logic signed [VALUE_W-1:0] sorted_model[QUEUE_DEPTH];
    int unsigned               model_count;

    int unsigned err_count;
    int unsigned run_cycles;
    int unsigned stall_cycles;
    queue_req_t  staged_req;
    queue_rsp_t  oldest_rsp;

    // applies one accepted request to the shadow queue and gives the response it owes
    function automatic queue_rsp_t predict_queue_op(input queue_req_t rq);
        queue_rsp_t  rs;
        int unsigned pos;
        rs.value  = '0;
        rs.status = ST_OK;
        case (rq.kind)
            REQ_INSERT:
            begin
                if (model_count >= QUEUE_DEPTH)
                    rs.status = ST_FULL;
                else
                begin
                    // new value goes ahead of any equal entries
                    pos = 0;
                    while (pos < model_count && sorted_model[pos] < rq.value)
                        pos++;
                    for (int k = model_count; k > pos; k--)
                        sorted_model[k] = sorted_model[k-1];
                    sorted_model[pos] = rq.value;
                    model_count++;
                end
            end
            REQ_EXTRACT:
            begin
                if (model_count == 0)
                    rs.status = ST_EMPTY;
                else
                begin
                    // largest value sits at the top of the ascending list
                    model_count--;
                    rs.value = sorted_model[model_count];
                end
            end
            REQ_READ:
            begin
                if (rq.index >= model_count)
                    rs.status = ST_INDEX;
                else
                    rs.value = sorted_model[rq.index];
            end
            default:
            begin
                // unused code leaves everything as it is
            end
        endcase
        rs.count = model_count[COUNT_W-1:0];
        return rs;
    endfunction

    function automatic queue_req_t make_req(input logic [REQ_W-1:0] kind,
                                            input logic signed [VALUE_W-1:0] value,
                                            input logic [INDEX_W-1:0] index);
        queue_req_t rq;
        rq.kind  = kind;
        rq.value = value;
        rq.index = index;
        return rq;
    endfunction

    // random request, inserts weighted by insert_pct so that phases fill or drain the queue
    function automatic queue_req_t random_req(input int unsigned insert_pct);
        queue_req_t  rq;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < insert_pct)
            rq.kind = REQ_INSERT;
        else
        begin
            pick = $urandom_range(99);
            if (pick < 58)
                rq.kind = REQ_EXTRACT;
            else if (pick < 95)
                rq.kind = REQ_READ;
            else
                rq.kind = REQ_UNUSED;
        end
        // a small pool of values makes equal entries common
        pick = $urandom_range(99);
        if (pick < 25)
            rq.value = $signed($urandom_range(4)) - 2 <<< 16;
        else if (pick < 30)
            rq.value = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        else
            rq.value = $urandom;
        rq.index = INDEX_W'($urandom_range(READ_SPAN - 1));
        return rq;
    endfunction

    function automatic bit quiet_now();
        return run_cycles >= QUIET_START && run_cycles < QUIET_END;
    endfunction

    function automatic bit take_gap();
        return !quiet_now() && $urandom_range(99) < IDLE_PCT;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_cycles <= 0;
        else
            run_cycles <= run_cycles + 1;
    end

    // request driver: predicts on each transfer, then offers the next pending request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.req_type   <= REQ_INSERT;
            req_ch.new_value  <= '0;
            req_ch.read_index <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_rsps.push_back(predict_queue_op(make_req(req_ch.req_type,
                                                                  req_ch.new_value,
                                                                  req_ch.read_index)));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() > 0 && !take_gap())
                begin
                    staged_req = pending_reqs.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.req_type   <= staged_req.kind;
                    req_ch.new_value  <= staged_req.value;
                    req_ch.read_index <= staged_req.index;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor: random back-pressure, each transfer checked against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            rsp_ch.ready <= !take_gap();
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch($sformatf(
                        "response with nothing expected: value %0d count %0d status %0d",
                        rsp_ch.out_value, rsp_ch.entry_count, rsp_ch.status));
                else
                begin
                    oldest_rsp = expected_rsps.pop_front();
                    if (rsp_ch.out_value !== oldest_rsp.value)
                        report_mismatch($sformatf("out_value %0d, expected %0d",
                                                  rsp_ch.out_value, oldest_rsp.value));
                    if (rsp_ch.entry_count !== oldest_rsp.count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  rsp_ch.entry_count, oldest_rsp.count));
                    if (rsp_ch.status !== oldest_rsp.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  rsp_ch.status, oldest_rsp.status.name()));
                end
            end
        end
    end

    // watchdog: too long without a transfer on either channel means the queue has hung
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("[sorted_priority_queue_top] ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // stimulus
    initial
    begin
        int unsigned issued;
        int unsigned phase_len;
        int unsigned insert_pct;
        bit          paused;

        err_count   = 0;
        model_count = 0;
        issued      = 0;
        paused      = 1'b0;
        // inputs known from time zero
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_INSERT;
        req_ch.new_value  = '0;
        req_ch.read_index = '0;
        rsp_ch.ready      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty queue, extremes, equal values, reads in and out of range, draining
        pending_reqs.push_back(make_req(REQ_EXTRACT, '0, '0));
        pending_reqs.push_back(make_req(REQ_READ, '0, 4'd0));
        pending_reqs.push_back(make_req(REQ_READ, '0, 4'd15));
        pending_reqs.push_back(make_req(REQ_UNUSED, 32'shffffffff, 4'd15));
        pending_reqs.push_back(make_req(REQ_INSERT, 32'sh7fffffff, '0));
        pending_reqs.push_back(make_req(REQ_INSERT, 32'sh80000000, '0));
        pending_reqs.push_back(make_req(REQ_INSERT, 32'sh00000000, '0));
        pending_reqs.push_back(make_req(REQ_INSERT, 32'sh00000000, '0));
        pending_reqs.push_back(make_req(REQ_INSERT, 32'sh00010000, '0));
        pending_reqs.push_back(make_req(REQ_READ, '0, 4'd0));
        pending_reqs.push_back(make_req(REQ_READ, '0, 4'd4));
        pending_reqs.push_back(make_req(REQ_READ, '0, 4'd5));
        pending_reqs.push_back(make_req(REQ_READ, '0, 4'd15));
        pending_reqs.push_back(make_req(REQ_UNUSED, '0, 4'd0));
        pending_reqs.push_back(make_req(REQ_EXTRACT, '0, '0));
        pending_reqs.push_back(make_req(REQ_EXTRACT, '0, '0));
        pending_reqs.push_back(make_req(REQ_EXTRACT, '0, '0));
        pending_reqs.push_back(make_req(REQ_EXTRACT, '0, '0));
        // last remaining entry, count drops to zero
        pending_reqs.push_back(make_req(REQ_EXTRACT, '0, '0));
        pending_reqs.push_back(make_req(REQ_EXTRACT, '0, '0));

        // sender holds off until the queue has answered everything
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(negedge clk);

        // random phases, some filling the queue past full, some draining it past empty
        while (issued < RANDOM_ITEMS)
        begin
            if (issued == 0)
            begin
                insert_pct = 95;
                phase_len  = 24;
            end
            else
            begin
                case ($urandom_range(4))
                    0: insert_pct = 90;
                    1: insert_pct = 70;
                    2: insert_pct = 50;
                    3: insert_pct = 25;
                    default: insert_pct = 5;
                endcase
                phase_len = $urandom_range(80, 20);
            end
            repeat (phase_len)
                pending_reqs.push_back(random_req(insert_pct));
            issued += phase_len;
            // keep the backlog short so that the pause below lands mid-run
            while (pending_reqs.size() > 8)
                @(negedge clk);
            if (!paused && issued >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
                    @(negedge clk);
            end
        end

        // drain, then leave time for any stray response
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (err_count == 0)
            $display("[sorted_priority_queue_top] OK");
        else
            $display("[sorted_priority_queue_top] ERROR");
        $finish;
    end

endmodule
